// ----- sv/rtc3w_pkg.sv -----
package rtc3w_pkg;

    // Transaction phases of the serial bus sequencer.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_WDATA = 3'd2,
        PH_GAP   = 3'd3,
        PH_VCMD  = 3'd4,
        PH_RDATA = 3'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_REJECT   = 2'd2
    } status_t;

    // Input item kinds carried on tuser.
    localparam logic REQ_NEW  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Time field selectors; the last one is the year.
    localparam logic [2:0] FLD_SEC     = 3'd0;
    localparam logic [2:0] FLD_MIN     = 3'd1;
    localparam logic [2:0] FLD_HOUR    = 3'd2;
    localparam logic [2:0] FLD_DATE    = 3'd3;
    localparam logic [2:0] FLD_MONTH   = 3'd4;
    localparam logic [2:0] FLD_WEEKDAY = 3'd5;
    localparam logic [2:0] FLD_LAST    = 3'd6;
    localparam logic [7:0] BCD_MAX     = 8'd99;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] READ_FLAG   = 8'h01;

    // Write command address for each time field; the read command sets bit 0.
    function automatic logic [7:0] wr_addr(input logic [2:0] f);
        logic [7:0] a;
        case (f)
            FLD_SEC:     a = 8'h80;
            FLD_MIN:     a = 8'h82;
            FLD_HOUR:    a = 8'h84;
            FLD_DATE:    a = 8'h86;
            FLD_MONTH:   a = 8'h88;
            FLD_WEEKDAY: a = 8'h8A;
            FLD_LAST:    a = 8'h8C;
            default:     a = 8'h80;
        endcase
        return a;
    endfunction

    // Tens digit mask for each BCD field.
    function automatic logic [7:0] tens_mask(input logic [2:0] f);
        logic [7:0] m;
        case (f)
            FLD_SEC, FLD_MIN:   m = 8'h70;
            FLD_HOUR, FLD_DATE: m = 8'h30;
            FLD_MONTH:          m = 8'h10;
            FLD_LAST:           m = 8'hF0;
            default:            m = 8'h00;
        endcase
        return m;
    endfunction

    // Turn a raw register byte into a decimal value; weekday passes through.
    function automatic logic [7:0] decode_field(input logic [2:0] f, input logic [7:0] raw);
        logic [7:0] masked;
        logic [3:0] tens;
        logic [3:0] nib;
        logic [3:0] units;
        logic [7:0] res;
        masked = raw & tens_mask(f);
        tens   = masked[7:4];
        nib    = raw[3:0];
        units  = (nib >= 4'd10) ? nib - 4'd10 : nib;
        if (f == FLD_WEEKDAY || f > FLD_LAST) begin
            res = raw;
        end else begin
            res = 8'({tens, 3'b000}) + 8'({tens, 1'b0}) + 8'(units);
        end
        return res;
    endfunction

    // BCD encoding of a value below 100; division by ten through a reciprocal.
    function automatic logic [7:0] encode_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [7:0]  rest;
        prod = 16'(v) * 16'd205;
        tens = prod[14:11];
        rest = v - (8'({tens, 3'b000}) + 8'({tens, 1'b0}));
        return {tens, rest[3:0]};
    endfunction

endpackage

// ----- sv/rtc_three_wire_bcd_master_core.sv -----
// Channel  Direction  tuser      tdata (lowest bit first)
// s_       in         req_type   field_sel[2:0] write_req[3] write_value[11:4] data_pin[12]
// m_       out        -          chip_enable clock_pulse data_out data_drive busy_res
//                                done_res read_value[13:6] status[15:14]
//
// Every input transaction yields exactly one result transaction, computed combinationally
// from the sequencer state and held in the output register.
// A new input transaction is taken each cycle while the output register is empty or
// being drained, so sustained rate is one item per clock.
// A stall on m_ holds the result and deasserts s_tready; aresetn (synchronous, active
// low) returns the sequencer to idle and empties the output register.
module rtc_three_wire_bcd_master_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // req_type
    input  logic [15:0] s_tdata,   // field_sel, write_req, write_value, data_pin
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // chip_enable, clock_pulse, data_out, data_drive,
                                   // busy_res, done_res, read_value, status
);
    import rtc3w_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] read_accum_reg, read_accum_next;
    logic [2:0] field_held_reg, field_held_next;
    logic       write_pending_reg, write_pending_next;
    logic [7:0] expected_reg, expected_next;
    logic [7:0] encoded_reg, encoded_next;

    logic        out_valid_reg;
    logic [15:0] out_data_reg, out_data_next;

    logic       accept;
    logic [2:0] in_field;
    logic       in_wreq;
    logic [7:0] in_wval;
    logic       in_dpin;
    logic [2:0] cur_field;
    logic [3:0] count_inc;
    logic [7:0] accum_upd;
    logic [7:0] decoded;
    logic       bad_req;

    logic       ce, clk_p, dout, drv, done;
    logic [7:0] rval;
    status_t    st;

    assign in_field = s_tdata[2:0];
    assign in_wreq  = s_tdata[3];
    assign in_wval  = s_tdata[11:4];
    assign in_dpin  = s_tdata[12];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Shared datapath terms for the tick phases and the new-request check.
    assign cur_field = (field_held_reg > FLD_LAST) ? 3'd0 : field_held_reg;
    assign count_inc = bit_count_reg + 4'd1;
    assign accum_upd = read_accum_reg | (8'(in_dpin) << bit_count_reg[2:0]);
    assign decoded   = decode_field(cur_field, accum_upd);
    assign bad_req   = (in_field > FLD_LAST)
                     || (in_wreq && in_field != FLD_WEEKDAY && in_wval > BCD_MAX);

    // Next state of the sequencer.
    always_comb begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_next         = shift_reg;
        read_accum_next    = read_accum_reg;
        field_held_next    = field_held_reg;
        write_pending_next = write_pending_reg;
        expected_next      = expected_reg;
        encoded_next       = encoded_reg;
        if (s_tuser == REQ_NEW) begin
            if (phase_reg == PH_IDLE && !bad_req) begin
                field_held_next    = in_field;
                write_pending_next = in_wreq;
                expected_next      = in_wval;
                encoded_next       = (in_field == FLD_WEEKDAY) ? in_wval : encode_bcd(in_wval);
                shift_next         = wr_addr(in_field) | (in_wreq ? 8'h00 : READ_FLAG);
                bit_count_next     = 4'd0;
                phase_next         = PH_CMD;
            end
        end else begin
            case (phase_reg)
                PH_CMD, PH_WDATA, PH_VCMD: begin
                    shift_next     = shift_reg >> 1;
                    bit_count_next = count_inc;
                    if (count_inc >= BITS_PER_BYTE) begin
                        bit_count_next = 4'd0;
                        if (phase_reg == PH_CMD && write_pending_reg) begin
                            phase_next = PH_WDATA;
                            shift_next = encoded_reg;
                        end else if (phase_reg == PH_WDATA) begin
                            phase_next = PH_GAP;
                        end else begin
                            phase_next      = PH_RDATA;
                            read_accum_next = 8'h00;
                        end
                    end
                end
                PH_GAP: begin
                    shift_next     = wr_addr(cur_field) | READ_FLAG;
                    bit_count_next = 4'd0;
                    phase_next     = PH_VCMD;
                end
                PH_RDATA: begin
                    read_accum_next = accum_upd;
                    bit_count_next  = count_inc;
                    if (count_inc >= BITS_PER_BYTE) begin
                        bit_count_next     = 4'd0;
                        write_pending_next = 1'b0;
                        phase_next         = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result fields for this transaction.
    always_comb begin
        ce    = 1'b0;
        clk_p = 1'b0;
        dout  = 1'b0;
        drv   = 1'b0;
        done  = 1'b0;
        rval  = 8'h00;
        st    = ST_OK;
        if (s_tuser == REQ_NEW) begin
            ce = (phase_reg == PH_CMD) || (phase_reg == PH_WDATA)
              || (phase_reg == PH_VCMD) || (phase_reg == PH_RDATA);
            if (phase_reg != PH_IDLE) begin
                st = ST_REJECT;
            end else if (bad_req) begin
                st   = ST_REJECT;
                done = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_CMD, PH_WDATA, PH_VCMD: begin
                    ce    = 1'b1;
                    clk_p = 1'b1;
                    drv   = 1'b1;
                    dout  = shift_reg[0];
                end
                PH_RDATA: begin
                    ce    = 1'b1;
                    clk_p = 1'b1;
                    if (count_inc >= BITS_PER_BYTE) begin
                        done = 1'b1;
                        rval = decoded;
                        if (write_pending_reg && decoded != expected_reg) begin
                            st = ST_MISMATCH;
                        end
                    end
                end
                default: begin
                    ce = 1'b0;
                end
            endcase
        end
        out_data_next = {st, rval, done, (phase_next != PH_IDLE), drv, dout, clk_p, ce};
    end

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= 4'd0;
            shift_reg         <= 8'h00;
            read_accum_reg    <= 8'h00;
            field_held_reg    <= 3'd0;
            write_pending_reg <= 1'b0;
            expected_reg      <= 8'h00;
            encoded_reg       <= 8'h00;
        end else if (accept) begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            shift_reg         <= shift_next;
            read_accum_reg    <= read_accum_next;
            field_held_reg    <= field_held_next;
            write_pending_reg <= write_pending_next;
            expected_reg      <= expected_next;
            encoded_reg       <= encoded_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- verif/rtc_three_wire_bcd_master_checker.sv -----
`timescale 1ns / 1ps

module rtc_three_wire_bcd_master_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tuser,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    import rtc3w_pkg::*;

    localparam logic [7:0] CMD_BASE = 8'h80;

    // Input transaction fields, lowest bit last in the declaration.
    typedef struct packed {
        logic [2:0] pad;
        logic       pin;
        logic [7:0] wval;
        logic       wreq;
        logic [2:0] fsel;
    } request_word_t;

    // One bus period as the result transaction carries it.
    typedef struct packed {
        status_t    st;
        logic [7:0] rval;
        logic       done;
        logic       busy;
        logic       drv;
        logic       dout;
        logic       clk;
        logic       ce;
    } bus_period_t;

    // Own copy of the sequencer state.
    phase_t     seq_phase      = PH_IDLE;
    logic [3:0] bit_idx        = '0;
    logic [7:0] tx_shift       = '0;
    logic [7:0] rx_byte        = '0;
    logic [2:0] cur_field      = '0;
    logic       verify_pending = 1'b0;
    logic [7:0] want_value     = '0;
    logic [7:0] wr_byte        = '0;

    bus_period_t pending_periods[$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Write command address of a field; the read command adds the read flag.
    function automatic logic [7:0] cmd_addr(input logic [2:0] f);
        return CMD_BASE | {4'b0000, f, 1'b0};
    endfunction

    function automatic logic [7:0] dec_to_bcd(input logic [7:0] v);
        int tens;
        int units;
        tens  = v / 10;
        units = v % 10;
        return 8'(tens * 16 + units);
    endfunction

    // Decimal value of a register byte, with the per-field tens masks.
    function automatic logic [7:0] bcd_to_dec(input logic [2:0] f, input logic [7:0] raw);
        logic [7:0] mask;
        int         tens;
        int         units;
        case (f)
            FLD_SEC, FLD_MIN:   mask = 8'h70;
            FLD_HOUR, FLD_DATE: mask = 8'h30;
            FLD_MONTH:          mask = 8'h10;
            FLD_LAST:           mask = 8'hF0;
            default:            mask = 8'h00;
        endcase
        if (f == FLD_WEEKDAY) begin
            return raw;
        end
        tens  = (raw & mask) >> 4;
        units = raw[3:0] % 10;
        return 8'(tens * 10 + units);
    endfunction

    // Advance the sequencer by one input transaction and give its bus period.
    function automatic bus_period_t serial_step(input logic kind, input request_word_t in);
        bus_period_t r;
        logic [7:0]  v;
        r = '0;
        if (kind == REQ_NEW) begin
            r.ce = (seq_phase == PH_CMD || seq_phase == PH_WDATA ||
                    seq_phase == PH_VCMD || seq_phase == PH_RDATA);
            if (seq_phase != PH_IDLE) begin
                r.st = ST_REJECT;
            end else if (in.fsel > FLD_LAST ||
                         (in.wreq && in.fsel != FLD_WEEKDAY && in.wval > BCD_MAX)) begin
                r.st   = ST_REJECT;
                r.done = 1'b1;
            end else begin
                cur_field      = in.fsel;
                verify_pending = in.wreq;
                want_value     = in.wval;
                wr_byte        = (in.fsel == FLD_WEEKDAY) ? in.wval : dec_to_bcd(in.wval);
                tx_shift       = cmd_addr(in.fsel) | (in.wreq ? 8'h00 : READ_FLAG);
                bit_idx        = '0;
                seq_phase      = PH_CMD;
            end
        end else begin
            case (seq_phase)
                // Master drives a bit out on each period.
                PH_CMD, PH_WDATA, PH_VCMD: begin
                    r.ce     = 1'b1;
                    r.clk    = 1'b1;
                    r.drv    = 1'b1;
                    r.dout   = tx_shift[0];
                    tx_shift = tx_shift >> 1;
                    bit_idx  = bit_idx + 4'd1;
                    if (bit_idx >= BITS_PER_BYTE) begin
                        bit_idx = '0;
                        if (seq_phase == PH_CMD && verify_pending) begin
                            seq_phase = PH_WDATA;
                            tx_shift  = wr_byte;
                        end else if (seq_phase == PH_WDATA) begin
                            seq_phase = PH_GAP;
                        end else begin
                            seq_phase = PH_RDATA;
                            rx_byte   = '0;
                        end
                    end
                end
                // Chip enable drops for one period before the read-back.
                PH_GAP: begin
                    tx_shift  = cmd_addr(cur_field) | READ_FLAG;
                    bit_idx   = '0;
                    seq_phase = PH_VCMD;
                end
                // Master samples the data pin, least significant bit first.
                PH_RDATA: begin
                    r.ce    = 1'b1;
                    r.clk   = 1'b1;
                    rx_byte = rx_byte | (8'(in.pin) << bit_idx[2:0]);
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx >= BITS_PER_BYTE) begin
                        v              = bcd_to_dec(cur_field, rx_byte);
                        bit_idx        = '0;
                        r.done         = 1'b1;
                        r.rval         = v;
                        r.st           = (verify_pending && v != want_value) ?
                                         ST_MISMATCH : ST_OK;
                        verify_pending = 1'b0;
                        seq_phase      = PH_IDLE;
                    end
                end
                default: begin
                    seq_phase = PH_IDLE;
                end
            endcase
        end
        r.busy = (seq_phase != PH_IDLE);
        return r;
    endfunction

    task automatic compare(input string what, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s differs, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Match each result transaction against the oldest prediction, then
    // predict the input transaction taken at this edge.
    always @(posedge aclk) begin
        bus_period_t want;
        bus_period_t got;
        if (!aresetn) begin
            seq_phase      = PH_IDLE;
            bit_idx        = '0;
            tx_shift       = '0;
            rx_byte        = '0;
            cur_field      = '0;
            verify_pending = 1'b0;
            want_value     = '0;
            wr_byte        = '0;
            pending_periods.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_periods.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = pending_periods.pop_front();
                    compare("chip_enable", want.ce, got.ce);
                    compare("clock_pulse", want.clk, got.clk);
                    compare("data_out", want.dout, got.dout);
                    compare("data_drive", want.drv, got.drv);
                    compare("busy_res", want.busy, got.busy);
                    compare("done_res", want.done, got.done);
                    compare("read_value", want.rval, got.rval);
                    compare("status", int'(want.st), int'(got.st));
                end
            end
            if (s_tvalid && s_tready) begin
                pending_periods.push_back(serial_step(s_tuser, s_tdata));
            end
        end
        outstanding = pending_periods.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rtc3w_pkg::*;

    localparam int ITEM_TARGET = 800;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser  = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int fail_count;
    int outstanding;
    int items_sent = 0;

    always #5 aclk = ~aclk;

    rtc_three_wire_bcd_master_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rtc_three_wire_bcd_master_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Offer one input transaction, with random gaps outside the steady stretch.
    task automatic offer(input logic kind, input logic [2:0] fsel, input logic wreq,
                         input logic [7:0] wval, input logic pin, input bit counted);
        bit gaps_on;
        gaps_on = !(items_sent >= 400 && items_sent < 560);
        while (gaps_on && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, pin, wval, wreq, fsel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) begin
            items_sent++;
        end
    endtask

    // A bit period; the request fields are don't-care and get random values.
    task automatic tick(input logic pin);
        offer(REQ_TICK, 3'($urandom), 1'($urandom), 8'($urandom), pin, 1'b1);
    endtask

    // A full read or write-with-verify; the read-back byte either echoes the
    // written value or is random.
    task automatic run_transfer(input logic [2:0] fsel, input logic wreq,
                                input logic [7:0] wval, input bit echo);
        int         n_ticks;
        logic [7:0] back;
        logic       pin;
        n_ticks = wreq ? 33 : 16;
        if (echo) begin
            back = (fsel == FLD_WEEKDAY) ? wval : 8'((wval / 10) * 16 + wval % 10);
        end else begin
            back = 8'($urandom);
        end
        offer(REQ_NEW, fsel, wreq, wval, 1'($urandom), 1'b1);
        for (int i = 0; i < n_ticks; i++) begin
            // A request that arrives mid-transfer is turned away.
            if ($urandom_range(0, 99) < 4) begin
                offer(REQ_NEW, 3'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 1'b0);
            end
            pin = (i >= n_ticks - 8) ? back[i - n_ticks + 8] : 1'($urandom);
            tick(pin);
        end
    endtask

    // Result side: random stalls, one long hold-off and one steady stretch.
    initial begin : ready_driver
        int cyc;
        cyc = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (cyc >= 200 && cyc < 320) begin
                m_tready <= 1'b0;
            end else if (cyc >= 900 && cyc < 1400) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 36);
            end
            @(posedge aclk);
            cyc++;
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        logic [2:0] fsel;
        logic       wreq;
        logic [7:0] wval;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, bad field for read and write, out-of-range BCD
        // write, then a read with all-ones data and a request while busy.
        offer(REQ_TICK, 3'h7, 1'b1, 8'hFF, 1'b1, 1'b1);
        offer(REQ_NEW, 3'h7, 1'b0, 8'h00, 1'b0, 1'b1);
        offer(REQ_NEW, 3'h7, 1'b1, 8'hFF, 1'b1, 1'b1);
        offer(REQ_NEW, FLD_LAST, 1'b1, BCD_MAX + 8'd1, 1'b0, 1'b1);
        offer(REQ_NEW, FLD_LAST, 1'b0, 8'h00, 1'b0, 1'b1);
        offer(REQ_NEW, FLD_WEEKDAY, 1'b1, 8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < 16; i++) begin
            tick(1'b1);
        end

        // Random: mostly complete transfers, some noise while idle.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 2))
                    0: tick(1'($urandom));
                    1: offer(REQ_NEW, 3'h7, 1'($urandom), 8'($urandom), 1'($urandom), 1'b1);
                    default: begin
                        fsel = 3'($urandom_range(0, 5));
                        if (fsel == FLD_WEEKDAY) begin
                            fsel = FLD_LAST;
                        end
                        offer(REQ_NEW, fsel, 1'b1, 8'($urandom_range(100, 255)),
                              1'($urandom), 1'b1);
                    end
                endcase
            end else begin
                fsel = 3'($urandom_range(0, 6));
                wreq = 1'($urandom);
                if (fsel == FLD_WEEKDAY) begin
                    wval = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
                end else if ($urandom_range(0, 9) == 0) begin
                    wval = $urandom_range(0, 1) ? BCD_MAX : 8'h00;
                end else begin
                    wval = 8'($urandom_range(0, 99));
                end
                run_transfer(fsel, wreq, wval, $urandom_range(0, 99) < 60);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        // Drain the remaining results, then let the pipeline settle.
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
